FILE: sv/cordic_coordinate_converter_macros.svh
// ----------------------------------------------------------------------------
// CORDIC coordinate converter assertion macros
// Shared assertion forms used by the converter's RTL.
// ----------------------------------------------------------------------------
`ifndef CORDIC_COORDINATE_CONVERTER_MACROS_SVH
`define CORDIC_COORDINATE_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define CCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles, disabled while reset is applied.
`define CCC_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

FILE: sv/ccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC coordinate converter package
// Widths, fixed-point constants, pipeline types and per-level constant tables.
// ----------------------------------------------------------------------------
package ccc_pkg;

    // Configuration of the datapath.
    localparam int ITERATIONS  = 16;
    localparam int DATA_WIDTH  = 16;
    localparam int SQRT_STEPS  = 16;
    localparam int NUM_LEVELS  = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;
    localparam int SHIFT_W     = $clog2(NUM_LEVELS);
    localparam int PREP_STAGES = 2;
    localparam int LATENCY     = PREP_STAGES + NUM_LEVELS + 1;

    // Field widths at the ports.
    localparam int COORD_W      = 16;
    localparam int ANGLE_W      = 16;
    localparam int RADIUS_IN_W  = 15;
    localparam int RADIUS_OUT_W = 16;

    // Internal widths: coordinates carry 16 fraction bits, angles are Q.30.
    localparam int FRAC_W  = 16;
    localparam int XW      = 36;
    localparam int ZW      = 35;
    localparam int SW      = 2 * SQRT_STEPS;
    localparam int GAIN_W  = 30;
    localparam int RPROD_W = RADIUS_IN_W + GAIN_W;

    // Shift amounts between the fixed-point formats.
    localparam int GAIN_SHIFT  = 14;
    localparam int ANGLE_SHIFT = 17;

    // Fixed-point constants.
    localparam logic [GAIN_W-1:0]    GAIN_Q30    = GAIN_W'(652032875);
    localparam logic [RPROD_W:0]     GAIN_ROUND  = (RPROD_W + 1)'(8192);
    localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic signed [ZW-1:0] ANGLE_LIM   = ZW'(64'sd25736);
    localparam logic signed [ZW-1:0] Z_ROUND     = ZW'(64'sd65536);
    localparam logic signed [XW-1:0] XY_ROUND    = XW'(64'sd32768);
    localparam logic signed [XW-1:0] XY_MAX      = XW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);

    // Payload that travels down the pipeline with each item.
    typedef struct packed {
        logic          rot;
        logic          origin;
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [ZW-1:0] z;
        logic [SW-1:0] rem;
        logic [SW-1:0] root;
    } stage_t;

    // Constant controls of one pipeline level.
    typedef struct packed {
        logic               cordic_en;
        logic               sqrt_en;
        logic [SHIFT_W-1:0] shift;
        logic [ZW-1:0]      atan;
        logic [SW-1:0]      sqrt_bit;
    } step_ctrl_t;

    // Arctangent of 2^-i in Q.30.
    function automatic logic [ZW-1:0] atan_q30(input int i);
        case (i)
            0:  return ZW'(843314857);
            1:  return ZW'(497837829);
            2:  return ZW'(263043837);
            3:  return ZW'(133525159);
            4:  return ZW'(67021687);
            5:  return ZW'(33543516);
            6:  return ZW'(16775851);
            7:  return ZW'(8388437);
            8:  return ZW'(4194283);
            9:  return ZW'(2097149);
            10: return ZW'(1048576);
            11: return ZW'(524288);
            12: return ZW'(262144);
            13: return ZW'(131072);
            14: return ZW'(65536);
            15: return ZW'(32768);
            16: return ZW'(16384);
            17: return ZW'(8192);
            18: return ZW'(4096);
            19: return ZW'(2048);
            20: return ZW'(1024);
            21: return ZW'(512);
            22: return ZW'(256);
            23: return ZW'(128);
            24: return ZW'(64);
            25: return ZW'(32);
            26: return ZW'(16);
            27: return ZW'(8);
            28: return ZW'(4);
            29: return ZW'(2);
            30: return ZW'(1);
            default: return '0;
        endcase
    endfunction

    // Trial bit of the square-root recurrence at step k, from the top pair down.
    function automatic logic [SW-1:0] sqrt_bit_of(input int k);
        logic [SW-1:0] bit_val;
        bit_val = '0;
        if (k < SQRT_STEPS)
        begin
            bit_val = SW'(1) << (2 * (SQRT_STEPS - 1 - k));
        end
        return bit_val;
    endfunction

    // All constant controls of level k.
    function automatic step_ctrl_t step_ctrl(input int k);
        step_ctrl_t c;
        c.cordic_en = (k < ITERATIONS);
        c.sqrt_en   = (k < SQRT_STEPS);
        c.shift     = SHIFT_W'(k);
        c.atan      = atan_q30(k);
        c.sqrt_bit  = sqrt_bit_of(k);
        return c;
    endfunction

endpackage

FILE: sv/ccc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC converter input preparation
// Two register stages: the multiplies, then the start vector, quadrant fold
// and square-root operand for the first pipeline level.
// ----------------------------------------------------------------------------
module ccc_prep (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic                                     command,
    input  logic signed [ccc_pkg::COORD_W-1:0]       x_in,
    input  logic signed [ccc_pkg::COORD_W-1:0]       y_in,
    input  logic signed [ccc_pkg::ANGLE_W-1:0]       angle_in,
    input  logic        [ccc_pkg::RADIUS_IN_W-1:0]   radius_in,
    output logic                                     out_valid,
    output ccc_pkg::stage_t                          out_data
);

    localparam int XPAD = ccc_pkg::XW - ccc_pkg::COORD_W - ccc_pkg::FRAC_W;
    localparam int ZPAD = ccc_pkg::ZW - ccc_pkg::ANGLE_W - ccc_pkg::ANGLE_SHIFT;

    // Stage A registers.
    logic                                     a_valid_reg;
    logic                                     a_rot_reg;
    logic signed [ccc_pkg::COORD_W-1:0]       a_x_reg;
    logic signed [ccc_pkg::COORD_W-1:0]       a_y_reg;
    logic signed [ccc_pkg::ANGLE_W-1:0]       a_angle_reg;
    logic        [ccc_pkg::SW-1:0]            a_sqx_reg;
    logic        [ccc_pkg::SW-1:0]            a_sqy_reg;
    logic        [ccc_pkg::RPROD_W-1:0]       a_rprod_reg;

    logic signed [2*ccc_pkg::COORD_W-1:0]     sqx_full;
    logic signed [2*ccc_pkg::COORD_W-1:0]     sqy_full;
    logic        [ccc_pkg::RPROD_W-1:0]       rprod_full;

    // Stage B signals.
    logic                                     b_valid_reg;
    ccc_pkg::stage_t                          b_data_reg;
    ccc_pkg::stage_t                          b_data_next;
    logic signed [ccc_pkg::XW-1:0]            xe;
    logic signed [ccc_pkg::XW-1:0]            ye;
    logic        [ccc_pkg::RPROD_W:0]         rsum;
    logic signed [ccc_pkg::XW-1:0]            xr;
    logic signed [ccc_pkg::ZW-1:0]            z0;

    // Squares for the magnitude and the gain-compensated radius.
    always_comb
    begin
        sqx_full   = x_in * x_in;
        sqy_full   = y_in * y_in;
        rprod_full = ccc_pkg::RPROD_W'(radius_in) * ccc_pkg::RPROD_W'(ccc_pkg::GAIN_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_rot_reg   <= command;
        a_x_reg     <= x_in;
        a_y_reg     <= y_in;
        a_angle_reg <= angle_in;
        a_sqx_reg   <= ccc_pkg::SW'($unsigned(sqx_full));
        a_sqy_reg   <= ccc_pkg::SW'($unsigned(sqy_full));
        a_rprod_reg <= rprod_full;
    end

    // Start vector: left half-plane points are turned by pi, large angles folded.
    always_comb
    begin
        xe   = $signed({{XPAD{a_x_reg[ccc_pkg::COORD_W-1]}}, a_x_reg,
                        {ccc_pkg::FRAC_W{1'b0}}});
        ye   = $signed({{XPAD{a_y_reg[ccc_pkg::COORD_W-1]}}, a_y_reg,
                        {ccc_pkg::FRAC_W{1'b0}}});
        rsum = {1'b0, a_rprod_reg} + ccc_pkg::GAIN_ROUND;
        xr   = $signed(ccc_pkg::XW'(rsum >> ccc_pkg::GAIN_SHIFT));
        z0   = $signed({{ZPAD{a_angle_reg[ccc_pkg::ANGLE_W-1]}}, a_angle_reg,
                        {ccc_pkg::ANGLE_SHIFT{1'b0}}});

        b_data_next.rot    = a_rot_reg;
        b_data_next.origin = (a_x_reg == '0) && (a_y_reg == '0);
        b_data_next.rem    = a_sqx_reg + a_sqy_reg;
        b_data_next.root   = '0;

        if (a_rot_reg)
        begin
            b_data_next.y = '0;
            if (z0 > ccc_pkg::HALF_PI_Q30)
            begin
                b_data_next.x = -xr;
                b_data_next.z = z0 - ccc_pkg::PI_Q30;
            end
            else if (z0 < -ccc_pkg::HALF_PI_Q30)
            begin
                b_data_next.x = -xr;
                b_data_next.z = z0 + ccc_pkg::PI_Q30;
            end
            else
            begin
                b_data_next.x = xr;
                b_data_next.z = z0;
            end
        end
        else if (a_x_reg[ccc_pkg::COORD_W-1])
        begin
            b_data_next.x = -xe;
            b_data_next.y = -ye;
            b_data_next.z = a_y_reg[ccc_pkg::COORD_W-1] ? -ccc_pkg::PI_Q30 : ccc_pkg::PI_Q30;
        end
        else
        begin
            b_data_next.x = xe;
            b_data_next.y = ye;
            b_data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_data_reg <= b_data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

FILE: sv/ccc_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC converter pipeline level
// One CORDIC micro-rotation and one square-root digit, registered.
// ----------------------------------------------------------------------------
module ccc_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ccc_pkg::stage_t     in_data,
    input  ccc_pkg::step_ctrl_t ctrl,
    output logic                out_valid,
    output ccc_pkg::stage_t     out_data
);

    logic                          valid_reg;
    ccc_pkg::stage_t               data_reg;
    ccc_pkg::stage_t               data_next;
    logic                          ccw;
    logic signed [ccc_pkg::XW-1:0] x_sh;
    logic signed [ccc_pkg::XW-1:0] y_sh;
    logic        [ccc_pkg::SW:0]   trial;

    // Rotation mode drives z to zero, vectoring mode drives y to zero.
    always_comb
    begin
        data_next = in_data;
        ccw       = in_data.rot ? ~in_data.z[ccc_pkg::ZW-1] : in_data.y[ccc_pkg::XW-1];
        x_sh      = $signed(in_data.x) >>> ctrl.shift;
        y_sh      = $signed(in_data.y) >>> ctrl.shift;
        trial     = {1'b0, in_data.root} + {1'b0, ctrl.sqrt_bit};

        if (ctrl.cordic_en)
        begin
            if (ccw)
            begin
                data_next.x = in_data.x - y_sh;
                data_next.y = in_data.y + x_sh;
                data_next.z = in_data.z - ctrl.atan;
            end
            else
            begin
                data_next.x = in_data.x + y_sh;
                data_next.y = in_data.y - x_sh;
                data_next.z = in_data.z + ctrl.atan;
            end
        end

        // Restoring square root, one result bit per level.
        if (ctrl.sqrt_en)
        begin
            if ({1'b0, in_data.rem} >= trial)
            begin
                data_next.rem  = in_data.rem - trial[ccc_pkg::SW-1:0];
                data_next.root = (in_data.root >> 1) + ctrl.sqrt_bit;
            end
            else
            begin
                data_next.root = in_data.root >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: sv/ccc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC converter output stage
// Final rounding, saturation and selection of the result fields.
// ----------------------------------------------------------------------------
module ccc_post (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  ccc_pkg::stage_t                          in_data,
    output logic                                     done,
    output logic signed [ccc_pkg::ANGLE_W-1:0]       angle_out,
    output logic        [ccc_pkg::RADIUS_OUT_W-1:0]  radius_out,
    output logic signed [ccc_pkg::COORD_W-1:0]       x_out,
    output logic signed [ccc_pkg::COORD_W-1:0]       y_out
);

    localparam logic signed [ccc_pkg::XW-1:0] XY_MIN = -ccc_pkg::XY_MAX - ccc_pkg::XW'(1);

    logic                                    done_reg;
    logic signed [ccc_pkg::ANGLE_W-1:0]      angle_reg;
    logic signed [ccc_pkg::ANGLE_W-1:0]      angle_next;
    logic        [ccc_pkg::RADIUS_OUT_W-1:0] radius_reg;
    logic        [ccc_pkg::RADIUS_OUT_W-1:0] radius_next;
    logic signed [ccc_pkg::COORD_W-1:0]      x_reg;
    logic signed [ccc_pkg::COORD_W-1:0]      x_next;
    logic signed [ccc_pkg::COORD_W-1:0]      y_reg;
    logic signed [ccc_pkg::COORD_W-1:0]      y_next;

    logic signed [ccc_pkg::ZW-1:0]           z_rnd;
    logic signed [ccc_pkg::ZW-1:0]           z_sat;
    logic signed [ccc_pkg::XW-1:0]           x_rnd;
    logic signed [ccc_pkg::XW-1:0]           y_rnd;
    logic signed [ccc_pkg::XW-1:0]           x_sat;
    logic signed [ccc_pkg::XW-1:0]           y_sat;
    logic        [ccc_pkg::RADIUS_OUT_W-1:0] root_rnd;

    // Round half up, then limit to the output ranges.
    always_comb
    begin
        z_rnd = ($signed(in_data.z) + ccc_pkg::Z_ROUND) >>> ccc_pkg::ANGLE_SHIFT;
        x_rnd = ($signed(in_data.x) + ccc_pkg::XY_ROUND) >>> ccc_pkg::FRAC_W;
        y_rnd = ($signed(in_data.y) + ccc_pkg::XY_ROUND) >>> ccc_pkg::FRAC_W;

        if (z_rnd > ccc_pkg::ANGLE_LIM)
        begin
            z_sat = ccc_pkg::ANGLE_LIM;
        end
        else if (z_rnd < -ccc_pkg::ANGLE_LIM)
        begin
            z_sat = -ccc_pkg::ANGLE_LIM;
        end
        else
        begin
            z_sat = z_rnd;
        end

        if (x_rnd > ccc_pkg::XY_MAX)
        begin
            x_sat = ccc_pkg::XY_MAX;
        end
        else if (x_rnd < XY_MIN)
        begin
            x_sat = XY_MIN;
        end
        else
        begin
            x_sat = x_rnd;
        end

        if (y_rnd > ccc_pkg::XY_MAX)
        begin
            y_sat = ccc_pkg::XY_MAX;
        end
        else if (y_rnd < XY_MIN)
        begin
            y_sat = XY_MIN;
        end
        else
        begin
            y_sat = y_rnd;
        end

        // The remainder exceeds the root exactly when the fraction is at least a half.
        root_rnd = in_data.root[ccc_pkg::RADIUS_OUT_W-1:0]
                 + ccc_pkg::RADIUS_OUT_W'(in_data.rem > in_data.root);
    end

    // Only the fields of the item's direction are non-zero.
    always_comb
    begin
        angle_next  = '0;
        radius_next = '0;
        x_next      = '0;
        y_next      = '0;
        if (in_data.rot)
        begin
            x_next = x_sat[ccc_pkg::COORD_W-1:0];
            y_next = y_sat[ccc_pkg::COORD_W-1:0];
        end
        else if (!in_data.origin)
        begin
            angle_next  = z_sat[ccc_pkg::ANGLE_W-1:0];
            radius_next = root_rnd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg  <= angle_next;
        radius_reg <= radius_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
    end

    assign done       = done_reg;
    assign angle_out  = angle_reg;
    assign radius_out = radius_reg;
    assign x_out      = x_reg;
    assign y_out      = y_reg;

endmodule

FILE: sv/cordic_coordinate_converter.sv
`timescale 1ns / 1ps
`include "cordic_coordinate_converter_macros.svh"
// ----------------------------------------------------------------------------
// CORDIC coordinate converter
// Rectangular to polar and polar to rectangular conversion in one pipeline.
// ----------------------------------------------------------------------------
// A new item may be started in every clock cycle; busy is always low. Each
// item passes through 19 register stages, the first loaded at the start edge:
// two preparation stages (the squares and gain multiply, then the start
// vector), one level per step of the sixteen CORDIC iterations, which also
// carry the sixteen digits of the square root for the magnitude, and one
// output register for rounding and saturation. The result is therefore shown
// on the output ports, marked by done, when it leaves the output register.
// Results leave in start order and the receiver must take each one in the
// cycle that it is shown.
module cordic_coordinate_converter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic                                     command,
    input  logic signed [ccc_pkg::COORD_W-1:0]       x_in,
    input  logic signed [ccc_pkg::COORD_W-1:0]       y_in,
    input  logic signed [ccc_pkg::ANGLE_W-1:0]       angle_in,
    input  logic        [ccc_pkg::RADIUS_IN_W-1:0]   radius_in,
    output logic                                     done,
    output logic signed [ccc_pkg::ANGLE_W-1:0]       angle_out,
    output logic        [ccc_pkg::RADIUS_OUT_W-1:0]  radius_out,
    output logic signed [ccc_pkg::COORD_W-1:0]       x_out,
    output logic signed [ccc_pkg::COORD_W-1:0]       y_out
);

    logic            level_valid [0:ccc_pkg::NUM_LEVELS];
    ccc_pkg::stage_t level_data  [0:ccc_pkg::NUM_LEVELS];
    logic            accept;

    // The pipeline never stalls, so an item is taken whenever one is offered.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input preparation.
    ccc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .command   (command),
        .x_in      (x_in),
        .y_in      (y_in),
        .angle_in  (angle_in),
        .radius_in (radius_in),
        .out_valid (level_valid[0]),
        .out_data  (level_data[0])
    );

    // One level per CORDIC iteration and square-root digit.
    for (genvar g = 0; g < ccc_pkg::NUM_LEVELS; g++)
    begin : g_level
        ccc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (level_valid[g]),
            .in_data   (level_data[g]),
            .ctrl      (ccc_pkg::step_ctrl(g)),
            .out_valid (level_valid[g+1]),
            .out_data  (level_data[g+1])
        );
    end

    // Rounding, saturation and result registers.
    ccc_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (level_valid[ccc_pkg::NUM_LEVELS]),
        .in_data    (level_data[ccc_pkg::NUM_LEVELS]),
        .done       (done),
        .angle_out  (angle_out),
        .radius_out (radius_out),
        .x_out      (x_out),
        .y_out      (y_out)
    );

    // Every accepted item gives its result after the pipeline latency.
    `CCC_ASSERT_DLY(a_item_completes, clk, rst_n, accept, (ccc_pkg::LATENCY), done, "accepted item gave no result")
    // No result appears without an item accepted one latency earlier.
    `CCC_ASSERT_IMP(a_no_spurious_result, clk, rst_n, done, $past(accept, ccc_pkg::LATENCY), "result without an accepted item")
    // A rectangular to polar result leaves the cartesian outputs at zero.
    `CCC_ASSERT_IMP(a_polar_clears_xy, clk, rst_n, done && !$past(command, ccc_pkg::LATENCY), (x_out == '0) && (y_out == '0), "cartesian outputs set on a polar result")
    // The angle output stays within plus or minus pi.
    `CCC_ASSERT_IMP(a_angle_range, clk, rst_n, done, (angle_out <= 16'sd25736) && (angle_out >= -16'sd25736), "angle output beyond pi")

endmodule

FILE: bench/cordic_coordinate_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC coordinate converter testbench
// Drives rectangular-to-polar and polar-to-rectangular items into the
// converter and predicts each result with a bit-exact fixed-point model. The
// prediction covers the CORDIC iterations, the rounded integer square root,
// angle limiting and output saturation. Each result is checked field by field
// in start order. Directed corner items come first, then three random phases
// with different sender idling.
// ----------------------------------------------------------------------------
module cordic_coordinate_converter_test;

    // Command codes.
    localparam logic CMD_TO_POLAR = 1'b0;
    localparam logic CMD_TO_RECT  = 1'b1;

    // Fixed-point constants of the conversion.
    localparam longint GAIN_K_Q30   = 64'sd652032875;
    localparam longint PI_Z_Q30     = 64'sd3373259426;
    localparam longint HALF_PI_Z_Q30 = 64'sd1686629713;
    localparam longint PI_ANGLE_Q13 = 64'sd25736;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     MAX_REPORTS  = 40;

    // One predicted conversion together with the item that caused it.
    typedef struct packed {
        logic               cmd;
        logic signed [15:0] x_arg;
        logic signed [15:0] y_arg;
        logic signed [15:0] ang_arg;
        logic [14:0]        rad_arg;
        logic signed [15:0] angle;
        logic [15:0]        radius;
        logic signed [15:0] xr;
        logic signed [15:0] yr;
    } conversion_t;

    // Arctangent of 2^-i in Q.30, one entry per CORDIC step.
    longint atan_step_q30 [0:31] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128,
        64, 32, 16, 8,
        4, 2, 1, 0
    };

    logic                                    clk;
    logic                                    rst_n;
    logic                                    start;
    logic                                    busy;
    logic                                    command;
    logic signed [ccc_pkg::COORD_W-1:0]      x_in;
    logic signed [ccc_pkg::COORD_W-1:0]      y_in;
    logic signed [ccc_pkg::ANGLE_W-1:0]      angle_in;
    logic        [ccc_pkg::RADIUS_IN_W-1:0]  radius_in;
    logic                                    done;
    logic signed [ccc_pkg::ANGLE_W-1:0]      angle_out;
    logic        [ccc_pkg::RADIUS_OUT_W-1:0] radius_out;
    logic signed [ccc_pkg::COORD_W-1:0]      x_out;
    logic signed [ccc_pkg::COORD_W-1:0]      y_out;

    conversion_t expected_conversions [$];
    int          error_count;
    int          polar_checked;
    int          rect_checked;
    int          idle_pct;
    int          stall_cycles;

    cordic_coordinate_converter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .x_in       (x_in),
        .y_in       (y_in),
        .angle_in   (angle_in),
        .radius_in  (radius_in),
        .done       (done),
        .angle_out  (angle_out),
        .radius_out (radius_out),
        .x_out      (x_out),
        .y_out      (y_out)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Limits a value to a closed range.
    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Square root rounded to nearest, halves upwards, digit by digit.
    function automatic longint round_sqrt(input longint s);
        longint root;
        longint rest;
        longint trial;
        root  = 0;
        rest  = s;
        trial = 64'sd1 <<< 40;
        while (trial > rest)
        begin
            trial = trial >>> 2;
        end
        while (trial != 0)
        begin
            if (rest >= root + trial)
            begin
                rest = rest - (root + trial);
                root = (root >>> 1) + trial;
            end
            else
            begin
                root = root >>> 1;
            end
            trial = trial >>> 2;
        end
        if (s - root * root > root)
        begin
            root = root + 1;
        end
        return root;
    endfunction

    // Predicts the converter's result for one item.
    function automatic conversion_t convert_coords(input logic cmd,
                                                   input logic signed [15:0] xv,
                                                   input logic signed [15:0] yv,
                                                   input logic signed [15:0] av,
                                                   input logic [14:0] rv);
        conversion_t res;
        longint      px;
        longint      py;
        longint      pz;
        longint      nx;
        longint      lim;
        int          steps;
        res         = '0;
        res.cmd     = cmd;
        res.x_arg   = xv;
        res.y_arg   = yv;
        res.ang_arg = av;
        res.rad_arg = rv;
        steps = (ccc_pkg::ITERATIONS > 32) ? 32 : ccc_pkg::ITERATIONS;
        lim   = (64'sd1 <<< (ccc_pkg::DATA_WIDTH - 1)) - 1;
        if (cmd == CMD_TO_POLAR)
        begin
            // The origin gives zero angle and zero magnitude.
            if (xv == 0 && yv == 0)
            begin
                return res;
            end
            res.radius = 16'(round_sqrt(longint'(xv) * longint'(xv)
                                        + longint'(yv) * longint'(yv)));
            px = longint'(xv) * 65536;
            py = longint'(yv) * 65536;
            pz = 0;
            // Points left of the y axis are turned by pi first.
            if (xv < 0)
            begin
                px = -px;
                py = -py;
                pz = (yv >= 0) ? PI_Z_Q30 : -PI_Z_Q30;
            end
            for (int k = 0; k < steps; k++)
            begin
                if (py >= 0)
                begin
                    nx = px + (py >>> k);
                    py = py - (px >>> k);
                    pz = pz + atan_step_q30[k];
                end
                else
                begin
                    nx = px - (py >>> k);
                    py = py + (px >>> k);
                    pz = pz - atan_step_q30[k];
                end
                px = nx;
            end
            res.angle = 16'(saturate((pz + 65536) >>> 17, -PI_ANGLE_Q13, PI_ANGLE_Q13));
        end
        else
        begin
            px = (longint'(rv) * GAIN_K_Q30 + 8192) >>> 14;
            py = 0;
            pz = longint'(av) * 131072;
            // Angles beyond a quarter turn are folded by pi.
            if (pz > HALF_PI_Z_Q30)
            begin
                pz = pz - PI_Z_Q30;
                px = -px;
            end
            else if (pz < -HALF_PI_Z_Q30)
            begin
                pz = pz + PI_Z_Q30;
                px = -px;
            end
            for (int k = 0; k < steps; k++)
            begin
                if (pz >= 0)
                begin
                    nx = px - (py >>> k);
                    py = py + (px >>> k);
                    pz = pz - atan_step_q30[k];
                end
                else
                begin
                    nx = px + (py >>> k);
                    py = py - (px >>> k);
                    pz = pz + atan_step_q30[k];
                end
                px = nx;
            end
            res.xr = 16'(saturate((px + 32768) >>> 16, -lim - 1, lim));
            res.yr = 16'(saturate((py + 32768) >>> 16, -lim - 1, lim));
        end
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string field, input longint got, input longint want,
                                   input conversion_t item);
        if (error_count < MAX_REPORTS)
        begin
            $display("[%0t] MISMATCH %s: got %0d, want %0d (command %0d x %0d y %0d angle %0d radius %0d)",
                     $realtime, field, got, want, item.cmd, item.x_arg, item.y_arg,
                     item.ang_arg, item.rad_arg);
        end
        error_count++;
    endtask

    // Sends one item, with random idle cycles ahead of it, and records its prediction.
    task automatic send_item(input logic cmd, input logic signed [15:0] xv,
                             input logic signed [15:0] yv, input logic signed [15:0] av,
                             input logic [14:0] rv);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start     <= 1'b1;
        command   <= cmd;
        x_in      <= xv;
        y_in      <= yv;
        angle_in  <= av;
        radius_in <= rv;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        expected_conversions.push_back(convert_coords(cmd, xv, yv, av, rv));
    endtask

    // Stops sending and waits until every predicted result has been checked.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_conversions.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Picks one of the boundary values of a signed 16-bit field.
    function automatic logic signed [15:0] edge_value();
        case ($urandom_range(0, 4))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    // Sends a random point to be converted to polar form.
    task automatic send_random_point();
        logic signed [15:0] xv;
        logic signed [15:0] yv;
        xv = 16'($urandom);
        yv = 16'($urandom);
        case ($urandom_range(0, 9))
            5:
            begin
                xv = 16'($urandom_range(0, 16) - 8);
                yv = 16'($urandom_range(0, 16) - 8);
            end
            6:       yv = '0;
            7:       xv = '0;
            8:
            begin
                xv = edge_value();
                yv = edge_value();
            end
            9:
            begin
                // Left half plane close to the negative x axis.
                xv = 16'(-int'($urandom_range(1, 32768)));
                yv = 16'($urandom_range(0, 8) - 4);
            end
            default: ;
        endcase
        send_item(CMD_TO_POLAR, xv, yv, 16'($urandom), 15'($urandom));
    endtask

    // Sends a random angle and radius to be converted to rectangular form.
    task automatic send_random_polar();
        logic signed [15:0] av;
        logic [14:0]        rv;
        av = 16'($urandom_range(0, 51472) - 25736);
        case ($urandom_range(0, 9))
            6:       av = 16'($urandom);
            7:
            begin
                // Close to the folding point at a quarter turn.
                av = 16'(12868 + $urandom_range(0, 4) - 2);
                if ($urandom_range(0, 1))
                begin
                    av = -av;
                end
            end
            8:
            begin
                av = 16'(25736 - $urandom_range(0, 3));
                if ($urandom_range(0, 1))
                begin
                    av = -av;
                end
            end
            9:       av = edge_value();
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0:       rv = 15'h7fff;
            1:       rv = 15'($urandom_range(0, 16));
            default: rv = 15'($urandom);
        endcase
        send_item(CMD_TO_RECT, 16'($urandom), 16'($urandom), av, rv);
    endtask

    // Corner points: origin, the seam at pi, axes and the largest magnitudes.
    task automatic test_point_corners();
        send_item(CMD_TO_POLAR, 16'sd0, 16'sd0, 16'sd1234, 15'd777);
        send_item(CMD_TO_POLAR, -16'sd5, 16'sd0, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, -16'sd5, -16'sd1, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, -16'sd32768, 16'sd0, -16'sd1, 15'h7fff);
        send_item(CMD_TO_POLAR, 16'sd32767, 16'sd32767, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, -16'sd32768, -16'sd32768, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, 16'sd32767, -16'sd32768, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, 16'sd0, -16'sd32768, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, 16'sd0, 16'sd32767, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, 16'sd1, 16'sd0, 16'sd0, 15'd0);
        send_item(CMD_TO_POLAR, -16'sd1, -16'sd1, 16'sd0, 15'd0);
        wait_drained();
    endtask

    // Corner angles and radii: fold boundaries, angles past pi, saturation.
    task automatic test_polar_corners();
        send_item(CMD_TO_RECT, -16'sd1, 16'sd1, 16'sd0, 15'h7fff);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, 16'sd25736, 15'h7fff);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, -16'sd25736, 15'h7fff);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, 16'sd32767, 15'h7fff);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, -16'sd32768, 15'h7fff);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, 16'sd12868, 15'd20000);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, 16'sd12867, 15'd20000);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, -16'sd12868, 15'd20000);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, 16'sd6434, 15'h7fff);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, 16'sd9000, 15'd0);
        send_item(CMD_TO_RECT, 16'sd0, 16'sd0, 16'sd0, 15'd1);
        wait_drained();
    endtask

    // A random mix of both directions, pausing for the pipeline to empty now and then.
    task automatic test_random_stream(input int count, input int pct);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(0, 63) == 0)
            begin
                wait_drained();
            end
            if ($urandom_range(0, 1))
            begin
                send_random_point();
            end
            else
            begin
                send_random_polar();
            end
        end
        wait_drained();
    endtask

    // Compares every result with the oldest prediction.
    always @(posedge clk)
    begin
        conversion_t want;
        if (rst_n && done)
        begin
            if (expected_conversions.size() == 0)
            begin
                want = '0;
                report_mismatch("unexpected result", 0, 0, want);
            end
            else
            begin
                want = expected_conversions.pop_front();
                if (angle_out !== want.angle)
                begin
                    report_mismatch("angle_out", angle_out, want.angle, want);
                end
                if (radius_out !== want.radius)
                begin
                    report_mismatch("radius_out", radius_out, want.radius, want);
                end
                if (x_out !== want.xr)
                begin
                    report_mismatch("x_out", x_out, want.xr, want);
                end
                if (y_out !== want.yr)
                begin
                    report_mismatch("y_out", y_out, want.yr, want);
                end
                if (want.cmd == CMD_TO_POLAR)
                begin
                    polar_checked++;
                end
                else
                begin
                    rect_checked++;
                end
            end
        end
    end

    // Ends the run when neither an item nor a result has been accepted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no item or result accepted for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Test sequence.
    initial
    begin
        error_count   = 0;
        polar_checked = 0;
        rect_checked  = 0;
        idle_pct      = 37;
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_TO_POLAR;
        x_in      = '0;
        y_in      = '0;
        angle_in  = '0;
        radius_in = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_point_corners();
        test_polar_corners();
        test_random_stream(165, 37);
        test_random_stream(165, 70);
        test_random_stream(165, 0);

        // Catch any stray result after the last one expected.
        repeat (ccc_pkg::LATENCY + 4) @(posedge clk);

        $display("Checked %0d rectangular-to-polar and %0d polar-to-rectangular results,",
                 polar_checked, rect_checked);
        $display("covering the origin, the pi seam, angle folding and output saturation.");
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/ccc_pkg.sv
sv/ccc_prep.sv
sv/ccc_stage.sv
sv/ccc_post.sv
sv/cordic_coordinate_converter.sv
bench/cordic_coordinate_converter_test.sv
